@@ sv/cmbm_pkg.sv @@
// ============================================================================
// cmbm_pkg
// Shared types and constants for the cell monitor and balance mask block.
// ============================================================================
package cmbm_pkg;

    // Number of cells in one measurement set.
    localparam int NUM_CELLS   = 10;
    localparam int MV_W        = 13;
    localparam int PACK_W      = 17;
    localparam int MASK_W      = 10;

    // Reduction trees are padded to a power of two.
    // The minimum tree also needs one leaf for the start value.
    localparam int TREE_LEAVES = 16;
    localparam int TREE_LEVELS = 4;

    // The excess sum is scaled by 25 first, then divided by 27.
    // The division is a multiply by ceil(2^26 / 27) followed by a shift.
    // This is exact for every scaled value below 2^21.
    localparam int                SCALED_W    = 21;
    localparam int                RECIP_W     = 22;
    localparam int                RECIP_SHIFT = 26;
    localparam int                PROD_W      = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M    = 22'd2485514;

    // Register stages from an accepted request to its result.
    localparam int PIPE_LAT    = 6;

    // Configuration port.
    localparam int CFG_AW      = 5;
    localparam int CFG_DW      = 32;

    typedef logic [MV_W-1:0] t_mv;

    localparam logic [2:0] REG_UNDER  = 3'd0;
    localparam logic [2:0] REG_OVER   = 3'd1;
    localparam logic [2:0] REG_DELTA  = 3'd2;
    localparam logic [2:0] REG_PERMIT = 3'd3;
    localparam logic [2:0] REG_START  = 3'd4;

    localparam t_mv RST_UNDER  = 13'd2700;
    localparam t_mv RST_OVER   = 13'd4200;
    localparam t_mv RST_DELTA  = 13'd25;
    localparam t_mv RST_PERMIT = 13'd3300;
    localparam t_mv RST_START  = 13'd4200;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_UNDER = 2'd1,
        FAULT_OVER  = 2'd2
    } t_fault;

    typedef struct packed {
        t_mv under_mv;
        t_mv over_mv;
        t_mv delta_mv;
        t_mv permit_mv;
        t_mv start_mv;
    } t_cfg;

    typedef struct packed {
        logic under;
        logic over;
        logic permit;
    } t_lane_flags;

    typedef struct packed {
        logic [PACK_W-1:0] pack;
        t_mv               low;
        logic              under;
        logic              over;
    } t_side;

endpackage

@@ sv/cmbm_lane.sv @@
// ============================================================================
// cmbm_lane
// Per-cell lane: threshold compares, then excess over the lowest cell and
// the balance decision once the lowest cell is known.
// ============================================================================
module cmbm_lane (
    input  logic                  i_clk,
    input  cmbm_pkg::t_mv         i_cell,
    input  cmbm_pkg::t_cfg        i_cfg,
    input  cmbm_pkg::t_mv         i_low,
    output cmbm_pkg::t_mv         o_cell,
    output cmbm_pkg::t_lane_flags o_flags,
    output cmbm_pkg::t_mv         o_excess,
    output logic                  o_bal
);

    cmbm_pkg::t_mv         r_cell;
    cmbm_pkg::t_lane_flags r_flags;
    cmbm_pkg::t_mv         r_cell_d;
    logic                  r_permit_d;
    cmbm_pkg::t_mv         r_excess;
    logic                  r_bal;

    cmbm_pkg::t_lane_flags n_flags;
    cmbm_pkg::t_mv         n_excess;
    logic                  n_bal;

    always_comb begin
        n_flags.under  = (i_cell < i_cfg.under_mv);
        n_flags.over   = (i_cell > i_cfg.over_mv);
        n_flags.permit = (i_cell > i_cfg.permit_mv);
        // The lowest value never exceeds any cell, so this cannot wrap.
        n_excess       = r_cell_d - i_low;
        n_bal          = (n_excess > i_cfg.delta_mv) && r_permit_d;
    end

    always_ff @(posedge i_clk) begin
        r_cell     <= i_cell;
        r_flags    <= n_flags;
        r_cell_d   <= r_cell;
        r_permit_d <= r_flags.permit;
        r_excess   <= n_excess;
        r_bal      <= n_bal;
    end

    assign o_cell   = r_cell;
    assign o_flags  = r_flags;
    assign o_excess = r_excess;
    assign o_bal    = r_bal;

endmodule

@@ sv/cmbm_merge.sv @@
// ============================================================================
// cmbm_merge
// Combines the lanes: minimum and sum trees with flag reduction, and later
// the sum tree over the per-lane excess values.
// ============================================================================
module cmbm_merge (
    input  logic                                              i_clk,
    input  logic [cmbm_pkg::NUM_CELLS-1:0][cmbm_pkg::MV_W-1:0] i_cells,
    input  cmbm_pkg::t_lane_flags [cmbm_pkg::NUM_CELLS-1:0]    i_flags,
    input  cmbm_pkg::t_mv                                     i_start_mv,
    input  logic [cmbm_pkg::NUM_CELLS-1:0][cmbm_pkg::MV_W-1:0] i_excess,
    output cmbm_pkg::t_mv                                     o_low,
    output logic [cmbm_pkg::PACK_W-1:0]                       o_pack,
    output logic                                              o_under,
    output logic                                              o_over,
    output logic [cmbm_pkg::PACK_W-1:0]                       o_excess_sum
);

    localparam int LEAVES = cmbm_pkg::TREE_LEAVES;
    localparam int LEVELS = cmbm_pkg::TREE_LEVELS;

    logic [cmbm_pkg::MV_W-1:0]   min_t [LEVELS+1][LEAVES];
    logic [cmbm_pkg::PACK_W-1:0] sum_t [LEVELS+1][LEAVES];
    logic [cmbm_pkg::PACK_W-1:0] exc_t [LEVELS+1][LEAVES];
    logic                        any_under;
    logic                        any_over;

    cmbm_pkg::t_mv               r_low;
    logic [cmbm_pkg::PACK_W-1:0] r_pack;
    logic                        r_under;
    logic                        r_over;
    logic [cmbm_pkg::PACK_W-1:0] r_excess_sum;

    always_comb begin
        any_under = 1'b0;
        any_over  = 1'b0;
        for (int i = 0; i < LEAVES; i++) begin
            if (i < cmbm_pkg::NUM_CELLS) begin
                min_t[0][i] = i_cells[i];
                sum_t[0][i] = cmbm_pkg::PACK_W'(i_cells[i]);
                exc_t[0][i] = cmbm_pkg::PACK_W'(i_excess[i]);
                any_under   = any_under | i_flags[i].under;
                any_over    = any_over | i_flags[i].over;
            end else if (i == cmbm_pkg::NUM_CELLS) begin
                // The start value joins the search as one more leaf.
                min_t[0][i] = i_start_mv;
                sum_t[0][i] = '0;
                exc_t[0][i] = '0;
            end else begin
                min_t[0][i] = '1;
                sum_t[0][i] = '0;
                exc_t[0][i] = '0;
            end
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int j = 0; j < LEAVES; j++) begin
                if (j < (LEAVES >> (l + 1))) begin
                    min_t[l+1][j] = (min_t[l][2*j] < min_t[l][2*j+1]) ?
                                    min_t[l][2*j] : min_t[l][2*j+1];
                    sum_t[l+1][j] = sum_t[l][2*j] + sum_t[l][2*j+1];
                    exc_t[l+1][j] = exc_t[l][2*j] + exc_t[l][2*j+1];
                end else begin
                    min_t[l+1][j] = '1;
                    sum_t[l+1][j] = '0;
                    exc_t[l+1][j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low        <= min_t[LEVELS][0];
        r_pack       <= sum_t[LEVELS][0];
        r_under      <= any_under;
        r_over       <= any_over;
        r_excess_sum <= exc_t[LEVELS][0];
    end

    assign o_low        = r_low;
    assign o_pack       = r_pack;
    assign o_under      = r_under;
    assign o_over       = r_over;
    assign o_excess_sum = r_excess_sum;

endmodule

@@ sv/cmbm_scale.sv @@
// ============================================================================
// cmbm_scale
// Scales the excess sum to hundredths of a percent, floor(sum * 25 / 27),
// in two stages: shift-and-add by 25, then reciprocal multiply by 1/27.
// ============================================================================
module cmbm_scale (
    input  logic                        i_clk,
    input  logic [cmbm_pkg::PACK_W-1:0] i_sum,
    output logic [cmbm_pkg::PACK_W-1:0] o_quot
);

    logic [cmbm_pkg::SCALED_W-1:0] sum_x;
    logic [cmbm_pkg::SCALED_W-1:0] n_scaled;
    logic [cmbm_pkg::PROD_W-1:0]   prod;

    logic [cmbm_pkg::SCALED_W-1:0] r_scaled;
    logic [cmbm_pkg::PACK_W-1:0]   r_quot;

    always_comb begin
        sum_x    = cmbm_pkg::SCALED_W'(i_sum);
        n_scaled = (sum_x << 4) + (sum_x << 3) + sum_x;
        prod     = cmbm_pkg::PROD_W'(r_scaled) * cmbm_pkg::PROD_W'(cmbm_pkg::RECIP_M);
    end

    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
        r_quot   <= prod[cmbm_pkg::RECIP_SHIFT +: cmbm_pkg::PACK_W];
    end

    assign o_quot = r_quot;

endmodule

@@ sv/cell_monitor_balance_mask.sv @@
// ============================================================================
// cell_monitor_balance_mask
// Pack monitor for one set of cell voltages: pack sum, lowest cell, bleed
// mask, imbalance figure, under/overvoltage flags and fault code.
// ============================================================================
// A request accepted on start is answered on o_done once it has passed the six
// register stages of lanes, merge trees and scaling.
// Throughput: one request per clock cycle outside reset; busy is high only during reset.
// Results cannot be stalled; each is shown for one cycle with o_done high.
// Reset (synchronous, active low) loads the register defaults and empties
// the pipeline, so no o_done follows a request from before reset.
// ============================================================================
module cell_monitor_balance_mask (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmbm_pkg::CFG_AW-1:0] paddr,
    input  logic [cmbm_pkg::CFG_DW-1:0] pwdata,
    output logic [cmbm_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,

    input  logic                        start,
    output logic                        busy,
    input  cmbm_pkg::t_mv               i_cell_0,
    input  cmbm_pkg::t_mv               i_cell_1,
    input  cmbm_pkg::t_mv               i_cell_2,
    input  cmbm_pkg::t_mv               i_cell_3,
    input  cmbm_pkg::t_mv               i_cell_4,
    input  cmbm_pkg::t_mv               i_cell_5,
    input  cmbm_pkg::t_mv               i_cell_6,
    input  cmbm_pkg::t_mv               i_cell_7,
    input  cmbm_pkg::t_mv               i_cell_8,
    input  cmbm_pkg::t_mv               i_cell_9,

    output logic                        o_done,
    output logic [cmbm_pkg::PACK_W-1:0] o_pack_mv,
    output cmbm_pkg::t_mv               o_lowest_mv,
    output logic [cmbm_pkg::MASK_W-1:0] o_balance_mask,
    output logic [cmbm_pkg::PACK_W-1:0] o_imbalance_hundredths,
    output logic                        o_under_flag,
    output logic                        o_over_flag,
    output logic [1:0]                  o_fault
);

    localparam int N   = cmbm_pkg::NUM_CELLS;
    localparam int LAT = cmbm_pkg::PIPE_LAT;

    // ------------------------------------------------------------------
    // Configuration registers. The register index is the word address.
    // Writes to unused indexes are dropped and read back as zero.
    // ------------------------------------------------------------------
    cmbm_pkg::t_cfg r_cfg;
    logic           cfg_wr;
    logic [2:0]     cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.under_mv  <= cmbm_pkg::RST_UNDER;
            r_cfg.over_mv   <= cmbm_pkg::RST_OVER;
            r_cfg.delta_mv  <= cmbm_pkg::RST_DELTA;
            r_cfg.permit_mv <= cmbm_pkg::RST_PERMIT;
            r_cfg.start_mv  <= cmbm_pkg::RST_START;
        end else if (cfg_wr) begin
            case (cfg_idx)
                cmbm_pkg::REG_UNDER:  r_cfg.under_mv  <= pwdata[cmbm_pkg::MV_W-1:0];
                cmbm_pkg::REG_OVER:   r_cfg.over_mv   <= pwdata[cmbm_pkg::MV_W-1:0];
                cmbm_pkg::REG_DELTA:  r_cfg.delta_mv  <= pwdata[cmbm_pkg::MV_W-1:0];
                cmbm_pkg::REG_PERMIT: r_cfg.permit_mv <= pwdata[cmbm_pkg::MV_W-1:0];
                cmbm_pkg::REG_START:  r_cfg.start_mv  <= pwdata[cmbm_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            cmbm_pkg::REG_UNDER:  prdata = cmbm_pkg::CFG_DW'(r_cfg.under_mv);
            cmbm_pkg::REG_OVER:   prdata = cmbm_pkg::CFG_DW'(r_cfg.over_mv);
            cmbm_pkg::REG_DELTA:  prdata = cmbm_pkg::CFG_DW'(r_cfg.delta_mv);
            cmbm_pkg::REG_PERMIT: prdata = cmbm_pkg::CFG_DW'(r_cfg.permit_mv);
            cmbm_pkg::REG_START:  prdata = cmbm_pkg::CFG_DW'(r_cfg.start_mv);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request tracking. Every stage advances each cycle, so a shift line
    // of valid bits marks which result leaves the last stage.
    // ------------------------------------------------------------------
    logic           accept;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;
    assign n_vld  = {r_vld[LAT-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // ------------------------------------------------------------------
    // Lanes: one per cell. Stage 1 registers the cell and its threshold
    // compares; stage 3 registers the excess over the lowest cell and the
    // bleed decision, using the lowest value the merge found in stage 2.
    // ------------------------------------------------------------------
    logic [N-1:0][cmbm_pkg::MV_W-1:0] in_cells;
    logic [N-1:0][cmbm_pkg::MV_W-1:0] lane_cell;
    cmbm_pkg::t_lane_flags [N-1:0]    lane_flags;
    logic [N-1:0][cmbm_pkg::MV_W-1:0] lane_excess;
    logic [N-1:0]                     lane_bal;

    assign in_cells = {i_cell_9, i_cell_8, i_cell_7, i_cell_6, i_cell_5,
                       i_cell_4, i_cell_3, i_cell_2, i_cell_1, i_cell_0};

    cmbm_pkg::t_mv               merge_low;
    logic [cmbm_pkg::PACK_W-1:0] merge_pack;
    logic                        merge_under;
    logic                        merge_over;
    logic [cmbm_pkg::PACK_W-1:0] merge_excess_sum;
    logic [cmbm_pkg::PACK_W-1:0] scale_quot;

    for (genvar g = 0; g < N; g++) begin : g_lane
        cmbm_lane u_lane (
            .i_clk    (i_clk),
            .i_cell   (in_cells[g]),
            .i_cfg    (r_cfg),
            .i_low    (merge_low),
            .o_cell   (lane_cell[g]),
            .o_flags  (lane_flags[g]),
            .o_excess (lane_excess[g]),
            .o_bal    (lane_bal[g])
        );
    end

    // Stage 2 gives the lowest cell, pack sum and flags; stage 4 the
    // excess sum.
    cmbm_merge u_merge (
        .i_clk        (i_clk),
        .i_cells      (lane_cell),
        .i_flags      (lane_flags),
        .i_start_mv   (r_cfg.start_mv),
        .i_excess     (lane_excess),
        .o_low        (merge_low),
        .o_pack       (merge_pack),
        .o_under      (merge_under),
        .o_over       (merge_over),
        .o_excess_sum (merge_excess_sum)
    );

    // Stages 5 and 6 turn the excess sum into hundredths of a percent.
    cmbm_scale u_scale (
        .i_clk  (i_clk),
        .i_sum  (merge_excess_sum),
        .o_quot (scale_quot)
    );

    // ------------------------------------------------------------------
    // Side results are delayed so they line up with the scaled figure.
    // ------------------------------------------------------------------
    cmbm_pkg::t_side             n_side;
    cmbm_pkg::t_side             r_side3;
    cmbm_pkg::t_side             r_side4;
    cmbm_pkg::t_side             r_side5;
    cmbm_pkg::t_side             r_side6;
    logic [cmbm_pkg::MASK_W-1:0] r_mask4;
    logic [cmbm_pkg::MASK_W-1:0] r_mask5;
    logic [cmbm_pkg::MASK_W-1:0] r_mask6;

    always_comb begin
        n_side.pack  = merge_pack;
        n_side.low   = merge_low;
        n_side.under = merge_under;
        n_side.over  = merge_over;
    end

    always_ff @(posedge i_clk) begin
        r_side3 <= n_side;
        r_side4 <= r_side3;
        r_side5 <= r_side4;
        r_side6 <= r_side5;
        r_mask4 <= cmbm_pkg::MASK_W'(lane_bal);
        r_mask5 <= r_mask4;
        r_mask6 <= r_mask5;
    end

    // Overvoltage takes priority over undervoltage in the fault code.
    cmbm_pkg::t_fault fault_sel;

    always_comb begin
        if (r_side6.over) begin
            fault_sel = cmbm_pkg::FAULT_OVER;
        end else if (r_side6.under) begin
            fault_sel = cmbm_pkg::FAULT_UNDER;
        end else begin
            fault_sel = cmbm_pkg::FAULT_NONE;
        end
    end

    assign o_done                 = r_vld[LAT-1];
    assign o_pack_mv              = r_side6.pack;
    assign o_lowest_mv            = r_side6.low;
    assign o_balance_mask         = r_mask6;
    assign o_imbalance_hundredths = scale_quot;
    assign o_under_flag           = r_side6.under;
    assign o_over_flag            = r_side6.over;
    assign o_fault                = fault_sel;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Every accepted request is answered after the fixed pipeline depth.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == $past(accept, LAT))
        else $error("result strobe does not match request timing");

    // The lowest cell never exceeds the configured start value.
    a_low_clamp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_lowest_mv <= r_cfg.start_mv))
        else $error("lowest cell above start value");

    // The fault code reports overvoltage exactly when the flag is set.
    a_fault_over : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_fault == cmbm_pkg::FAULT_OVER) == o_over_flag))
        else $error("fault code disagrees with overvoltage flag");

    // Without overvoltage, the fault code follows the undervoltage flag.
    a_fault_under : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_over_flag) |->
            ((o_fault == cmbm_pkg::FAULT_UNDER) == o_under_flag))
        else $error("fault code disagrees with undervoltage flag");

endmodule
